FILE: src/keyword_lexer_assert.svh
// Assertion helpers for keyword_lexer; expect clk_i and rst_ni in scope.
`ifndef KEYWORD_LEXER_ASSERT_SVH
`define KEYWORD_LEXER_ASSERT_SVH

// Same-cycle implication.
`define KL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyword_lexer: assertion failed");

// Next-cycle implication.
`define KL_ASSERT_NX(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyword_lexer: assertion failed");

`endif

FILE: src/kl_pkg.sv
package kl_pkg;

  localparam logic [3:0] KIND_STRING  = 4'd0;
  localparam logic [3:0] KIND_IDENT   = 4'd1;
  localparam logic [3:0] KIND_KEY0    = 4'd2;
  localparam logic [3:0] KIND_UNKNOWN = 4'd13;
  localparam logic [3:0] KIND_EOF     = 4'd14;

  localparam int KEY_COUNT = 11;
  localparam int KEY_MAX   = 12;
  localparam int KEY_IW    = $clog2(KEY_MAX);

  localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEY_MAX] = '{
    '{"c", "r", "e", "a", "t", "e", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"e", "n", "t", "i", "t", "y", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"r", "e", "l", "a", "t", "i", "o", "n", "s", "h", "i", "p"},
    '{"a", "d", "d", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"p", "r", "o", "p", "e", "r", "t", "y", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"c", "l", "e", "a", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"m", "o", "n", "e", "y", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"i", "n", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"s", "t", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"d", "o", "u", "b", "l", "e", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"d", "a", "t", "e", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0}
  };

  localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
    4'd6, 4'd6, 4'd12, 4'd3, 4'd8, 4'd5, 4'd5, 4'd3, 4'd3, 4'd6, 4'd4
  };

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] pos;
    logic [5:0]  len;
    logic        fin;
  } kl_res_t;

  // Results of one input item, slot 0 first.
  typedef struct packed {
    logic [1:0]        cnt;
    kl_res_t [2:0]     res;
  } kl_bundle_t;

endpackage

FILE: src/keyword_lexer.sv
// keyword_lexer: byte-serial tokenizer.
// Input queue side: text_byte_i / end_of_text_i are taken when push_i is high
// and full_o is low. A zero byte or end_of_text_i ends the text.
// Result queue side: while empty_o is low the oldest token descriptor sits on
// token_kind_o, position_o, token_length_o and final_res_o; pop_i takes it.
// The scanner takes one byte per cycle while full_o is low. Each byte yields
// zero to three results, which enter a four-entry queue as one bundle; the back
// end hands them out one per cycle, while pop_i is high, through a single
// output register; a result passes the queue and then the output register.
// Throughput: one byte per cycle while results are drained at least as fast
// as they appear; full_o rises once four bundles wait behind a stalled pop_i.
// After the eof token (final_res_o high) further bytes are accepted and
// dropped until reset. Reset clears the scanner, the queue pointers and the
// output valid flag; no clearing pass is needed.
module keyword_lexer import kl_pkg::*; #(
  parameter int MAX_TOKENS  = 63,
  parameter int MAX_RUN     = 63,
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] position_o,
  output logic [5:0]  token_length_o,
  output logic        final_res_o
);

  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  kl_bundle_t q_wdata;
  kl_bundle_t q_rdata;

  kl_front #(
    .MAX_TOKENS  (MAX_TOKENS),
    .MAX_RUN     (MAX_RUN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .full_o        (full_o),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  kl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  kl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_valid),
    .head_i         (q_rdata),
    .q_pop_o        (q_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .token_kind_o   (token_kind_o),
    .position_o     (position_o),
    .token_length_o (token_length_o),
    .final_res_o    (final_res_o)
  );

endmodule

FILE: src/kl_front.sv
module kl_front import kl_pkg::*; #(
  parameter int MAX_TOKENS  = 63,
  parameter int MAX_RUN     = 63,
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       q_full_i,
  output logic       full_o,
  output logic       q_push_o,
  output kl_bundle_t q_data_o
);

  localparam int RW = $clog2(MAX_RUN + 1);
  localparam int TW = $clog2(MAX_TOKENS + 1);
  localparam int OW = OFFSET_BITS;
  localparam int PW = (OW > 16) ? OW : 16;
  localparam int LW = (RW > 6) ? RW : 6;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_WORD,
    MODE_DONE
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [RW-1:0]        run_q, run_d;
  logic [OW-1:0]        off_q, off_d;
  logic [TW-1:0]        tok_q, tok_d;
  logic [KEY_COUNT-1:0] hits_q, hits_d;

  logic                 acc_c;
  logic                 end_c;
  logic                 space_c;
  logic                 quote_c;
  logic                 word_c;
  logic [OW-1:0]        off_inc;
  logic [3:0]           kind_c;
  logic [1:0]           cnt_c;
  kl_res_t [2:0]        res_c;
  logic                 idle_c;

  function automatic logic [15:0] pos16(input logic [OW-1:0] o);
    logic [PW-1:0] e;
    e = PW'(o);
    return e[15:0];
  endfunction

  function automatic logic [5:0] len6(input logic [RW-1:0] r);
    logic [LW-1:0] e;
    e = LW'(r);
    return e[5:0];
  endfunction

  function automatic logic [KEY_COUNT-1:0] key_match(input logic [KEY_COUNT-1:0] h,
                                                     input logic [7:0] c,
                                                     input logic [RW-1:0] idx);
    logic [KEY_COUNT-1:0] r;
    logic [KEY_IW-1:0]    i;
    r = h;
    i = idx[KEY_IW-1:0];
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (idx >= RW'(KEY_MAX) || KEY_TEXT[k][i] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  assign acc_c   = push_i && !q_full_i;
  assign full_o  = q_full_i;
  assign end_c   = end_of_text_i || (text_byte_i == 8'h00);
  assign space_c = (text_byte_i == 8'h20) || (text_byte_i >= 8'h09 && text_byte_i <= 8'h0d);
  assign quote_c = (text_byte_i == 8'h22) || (text_byte_i == 8'h27);
  assign word_c  = (text_byte_i >= "0" && text_byte_i <= "9") ||
                   (text_byte_i >= "a" && text_byte_i <= "z") ||
                   (text_byte_i >= "A" && text_byte_i <= "Z");
  assign off_inc = (off_q == '1) ? off_q : off_q + OW'(1);

  always_comb begin
    kind_c = KIND_IDENT;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (hits_q[k] && run_q == RW'(KEY_LEN[k])) begin
        kind_c = 4'(KIND_KEY0 + k);
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    run_d  = run_q;
    off_d  = off_q;
    tok_d  = tok_q;
    hits_d = hits_q;
    cnt_c  = '0;
    res_c  = '0;
    idle_c = (mode_q == MODE_IDLE);
    case (mode_q)
      MODE_STRING: begin
        if (end_c) begin
          res_c[cnt_c] = '{kind: KIND_EOF, pos: pos16(off_q), len: 6'd1, fin: 1'b1};
          cnt_c = cnt_c + 2'd1;
          mode_d = MODE_DONE;
        end else if (quote_c) begin
          off_d = off_inc;
          res_c[cnt_c] = '{kind: KIND_STRING, pos: pos16(off_inc), len: len6(run_q),
                           fin: 1'b0};
          cnt_c = cnt_c + 2'd1;
          mode_d = MODE_IDLE;
          run_d = '0;
          tok_d = tok_q + TW'(1);
          if (tok_d == TW'(MAX_TOKENS)) begin
            res_c[cnt_c] = '{kind: KIND_EOF, pos: pos16(off_inc), len: 6'd1, fin: 1'b1};
            cnt_c = cnt_c + 2'd1;
            mode_d = MODE_DONE;
          end
        end else if (run_q >= RW'(MAX_RUN)) begin
          res_c[cnt_c] = '{kind: KIND_EOF, pos: pos16(off_q), len: 6'd1, fin: 1'b1};
          cnt_c = cnt_c + 2'd1;
          mode_d = MODE_DONE;
        end else begin
          run_d = run_q + RW'(1);
          off_d = off_inc;
        end
      end
      MODE_WORD: begin
        if (!end_c && word_c && run_q < RW'(MAX_RUN)) begin
          hits_d = key_match(hits_q, text_byte_i, run_q);
          run_d = run_q + RW'(1);
          off_d = off_inc;
        end else begin
          res_c[cnt_c] = '{kind: kind_c, pos: pos16(off_q), len: len6(run_q), fin: 1'b0};
          cnt_c = cnt_c + 2'd1;
          mode_d = MODE_IDLE;
          run_d = '0;
          tok_d = tok_q + TW'(1);
          if (tok_d == TW'(MAX_TOKENS)) begin
            res_c[cnt_c] = '{kind: KIND_EOF, pos: pos16(off_q), len: 6'd1, fin: 1'b1};
            cnt_c = cnt_c + 2'd1;
            mode_d = MODE_DONE;
          end else begin
            idle_c = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (idle_c) begin
      if (end_c) begin
        res_c[cnt_c] = '{kind: KIND_EOF, pos: pos16(off_q), len: 6'd1, fin: 1'b1};
        cnt_c = cnt_c + 2'd1;
        mode_d = MODE_DONE;
      end else if (space_c) begin
        off_d = off_inc;
      end else if (quote_c) begin
        mode_d = MODE_STRING;
        run_d = '0;
        off_d = off_inc;
      end else if (word_c) begin
        mode_d = MODE_WORD;
        hits_d = key_match('1, text_byte_i, '0);
        run_d = RW'(1);
        off_d = off_inc;
      end else begin
        res_c[cnt_c] = '{kind: KIND_UNKNOWN, pos: pos16(off_q), len: 6'd1, fin: 1'b0};
        cnt_c = cnt_c + 2'd1;
        off_d = off_inc;
        tok_d = tok_d + TW'(1);
        if (tok_d == TW'(MAX_TOKENS)) begin
          res_c[cnt_c] = '{kind: KIND_EOF, pos: pos16(off_inc), len: 6'd1, fin: 1'b1};
          cnt_c = cnt_c + 2'd1;
          mode_d = MODE_DONE;
        end
      end
    end
  end

  assign q_push_o = acc_c && (cnt_c != 2'd0);
  assign q_data_o = '{cnt: cnt_c, res: res_c};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      run_q  <= '0;
      off_q  <= '0;
      tok_q  <= '0;
      hits_q <= '1;
    end else if (acc_c) begin
      mode_q <= mode_d;
      run_q  <= run_d;
      off_q  <= off_d;
      tok_q  <= tok_d;
      hits_q <= hits_d;
    end
  end

`include "keyword_lexer_assert.svh"

  `KL_ASSERT_NX(a_done_sticky, mode_q == MODE_DONE, mode_q == MODE_DONE)
  `KL_ASSERT(a_eof_last0, q_push_o, !q_data_o.res[0].fin || q_data_o.cnt == 2'd1)
  `KL_ASSERT(a_eof_last1, q_push_o, !q_data_o.res[1].fin || q_data_o.cnt == 2'd2)

endmodule

FILE: src/kl_queue.sv
module kl_queue import kl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  kl_bundle_t data_i,
  output logic       full_o,
  output logic       valid_o,
  output kl_bundle_t data_o,
  input  logic       pop_i
);

  kl_bundle_t            mem_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]   wptr_q, rptr_q;
  logic [QUEUE_PW:0]     cnt_q;
  logic                  wr_c;
  logic                  rd_c;

  assign full_o  = (cnt_q == (QUEUE_PW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign wr_c    = push_i && !full_o;
  assign rd_c    = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_c) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_c) begin
        wptr_q <= wptr_q + QUEUE_PW'(1);
      end
      if (rd_c) begin
        rptr_q <= rptr_q + QUEUE_PW'(1);
      end
      if (wr_c && !rd_c) begin
        cnt_q <= cnt_q + (QUEUE_PW+1)'(1);
      end else if (rd_c && !wr_c) begin
        cnt_q <= cnt_q - (QUEUE_PW+1)'(1);
      end
    end
  end

endmodule

FILE: src/kl_back.sv
module kl_back import kl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  kl_bundle_t head_i,
  output logic       q_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [3:0] token_kind_o,
  output logic [15:0] position_o,
  output logic [5:0] token_length_o,
  output logic       final_res_o
);

  kl_res_t    out_q;
  logic       vld_q;
  logic [1:0] sub_q;
  logic       take_c;
  logic       load_c;
  logic       last_c;

  assign take_c  = pop_i && vld_q;
  assign load_c  = head_valid_i && (!vld_q || take_c);
  assign last_c  = (sub_q == head_i.cnt - 2'd1);
  assign q_pop_o = load_c && last_c;

  always_ff @(posedge clk_i) begin
    if (load_c) begin
      out_q <= head_i.res[sub_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sub_q <= '0;
    end else begin
      if (load_c) begin
        vld_q <= 1'b1;
        sub_q <= last_c ? 2'd0 : sub_q + 2'd1;
      end else if (take_c) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign empty_o        = !vld_q;
  assign token_kind_o   = out_q.kind;
  assign position_o     = out_q.pos;
  assign token_length_o = out_q.len;
  assign final_res_o    = out_q.fin;

`include "keyword_lexer_assert.svh"

  `KL_ASSERT(a_sub_has_head, sub_q != 2'd0, head_valid_i)
  `KL_ASSERT(a_sub_in_range, head_valid_i, sub_q < head_i.cnt)

endmodule
